[hdl/lti_pkg.sv]
package lti_pkg;

  localparam int unsigned LIGHT_W     = 20;
  localparam int unsigned CORNER_W    = 16;
  localparam int unsigned TEXEL_W     = 8;
  localparam int unsigned COORD_W     = 4;
  localparam int unsigned MIP_W       = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 2;

  localparam logic [CORNER_W-1:0] LIGHT_HI_MASK = 16'hFF00;
  localparam logic [MIP_W-1:0]    MIP_SMALLEST  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MIP_LEVEL  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE = 1'b1;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TEXEL = 1'b1;

  // pixel orders
  localparam logic MODE_8BIT = 1'b0;
  localparam logic MODE_WIDE = 1'b1;

  typedef logic signed [LIGHT_W-1:0] light_t;

  typedef struct packed {
    light_t               edge_left_light;
    light_t               edge_right_light;
    light_t               edge_left_step;
    light_t               edge_right_step;
    light_t               pixel_light;
    light_t               pixel_step;
    logic [COORD_W-1:0]   row_counter;
    logic [COORD_W-1:0]   column_counter;
  } blk_state_t;

  typedef struct packed {
    logic [CORNER_W-1:0] map_index;
    logic [COORD_W-1:0]  pixel_column;
    logic [COORD_W-1:0]  pixel_row;
    logic                block_last;
  } pix_result_t;

  typedef struct packed {
    logic [CORNER_W-1:0] top_left;
    logic [CORNER_W-1:0] top_right;
    logic [CORNER_W-1:0] bottom_left;
    logic [CORNER_W-1:0] bottom_right;
  } corners_t;

endpackage

[hdl/lti_edge_setup.sv]
module lti_edge_setup
  import lti_pkg::*;
(
  input  corners_t         corners,
  input  logic [MIP_W-1:0] mip_level,
  output blk_state_t       state_nxt
);

  logic [2:0] shift;
  light_t     left_diff;
  light_t     right_diff;

  always_comb begin
    shift      = 3'd4 - {1'b0, mip_level};
    left_diff  = light_t'({4'b0, corners.bottom_left})  - light_t'({4'b0, corners.top_left});
    right_diff = light_t'({4'b0, corners.bottom_right}) - light_t'({4'b0, corners.top_right});

    state_nxt                  = '0;
    state_nxt.edge_left_light  = light_t'({4'b0, corners.top_left});
    state_nxt.edge_right_light = light_t'({4'b0, corners.top_right});
    state_nxt.edge_left_step   = left_diff >>> shift;
    state_nxt.edge_right_step  = right_diff >>> shift;
  end

endmodule

[hdl/lti_texel_path.sv]
module lti_texel_path
  import lti_pkg::*;
(
  input  blk_state_t         state,
  input  logic [MIP_W-1:0]   mip_level,
  input  logic               pixel_mode,
  input  logic [TEXEL_W-1:0] texel,
  output blk_state_t         state_nxt,
  output pix_result_t        result
);

  logic [2:0]              shift;
  logic [COORD_W:0]        edge_n;
  logic                    col_first;
  logic signed [LIGHT_W:0] span_diff;
  logic signed [LIGHT_W:0] span_shr;
  light_t                  row_light;
  light_t                  row_step;
  light_t                  light;
  logic [LIGHT_W:0]        mid_sum;
  logic                    row_end;
  logic                    blk_end;

  always_comb begin
    shift     = 3'd4 - {1'b0, mip_level};
    edge_n    = (COORD_W+1)'(5'd16 >> mip_level);
    col_first = (state.column_counter == '0);

    // edge difference kept one bit wider so the floor shift sees the true value
    span_diff = (pixel_mode == MODE_WIDE)
              ? {state.edge_right_light[LIGHT_W-1], state.edge_right_light}
                - {state.edge_left_light[LIGHT_W-1], state.edge_left_light}
              : {state.edge_left_light[LIGHT_W-1], state.edge_left_light}
                - {state.edge_right_light[LIGHT_W-1], state.edge_right_light};
    span_shr  = span_diff >>> shift;
    if (col_first) begin
      row_light = (pixel_mode == MODE_WIDE) ? state.edge_left_light : state.edge_right_light;
      row_step  = span_shr[LIGHT_W-1:0];
    end else begin
      row_light = state.pixel_light;
      row_step  = state.pixel_step;
    end

    // midpoint of the left and right edges, floor shift
    mid_sum = {state.edge_left_light[LIGHT_W-1], state.edge_left_light}
            + {state.edge_right_light[LIGHT_W-1], state.edge_right_light};
    if (pixel_mode == MODE_WIDE && mip_level == MIP_SMALLEST &&
        state.column_counter == COORD_W'(1)) begin
      light = light_t'(mid_sum[LIGHT_W:1]);
    end else begin
      light = row_light;
    end

    row_end = ({1'b0, state.column_counter} + (COORD_W+1)'(1)) >= edge_n;
    blk_end = ({1'b0, state.row_counter} + (COORD_W+1)'(1)) >= edge_n;

    result.map_index    = (light[CORNER_W-1:0] & LIGHT_HI_MASK) + {8'b0, texel};
    result.pixel_column = (pixel_mode == MODE_WIDE) ? state.column_counter
                        : COORD_W'(edge_n - (COORD_W+1)'(1) - {1'b0, state.column_counter});
    result.pixel_row    = state.row_counter;
    result.block_last   = row_end && blk_end;

    state_nxt             = state;
    state_nxt.pixel_light = row_light + row_step;
    state_nxt.pixel_step  = row_step;
    if (row_end) begin
      state_nxt.column_counter   = '0;
      state_nxt.edge_left_light  = state.edge_left_light + state.edge_left_step;
      state_nxt.edge_right_light = state.edge_right_light + state.edge_right_step;
      state_nxt.row_counter      = blk_end ? '0 : state.row_counter + COORD_W'(1);
    end else begin
      state_nxt.column_counter = state.column_counter + COORD_W'(1);
    end
  end

endmodule

[hdl/lit_texel_block_interpolator_core.sv]
// a texel transaction's result is registered and shows in the cycle after it is accepted
// throughput: one transaction per cycle, start and texel alike; the block stalls
//   only while its output register holds a result that is itself stalled
// a start transaction updates the edge state and produces no result
// reset (rst_n low, synchronous): edge state, counters, configuration and the
//   output valid clear to zero
module lit_texel_block_interpolator_core
  import lti_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_req_type,
  input  logic [CORNER_W-1:0]    in_corner_top_left,
  input  logic [CORNER_W-1:0]    in_corner_top_right,
  input  logic [CORNER_W-1:0]    in_corner_bottom_left,
  input  logic [CORNER_W-1:0]    in_corner_bottom_right,
  input  logic [TEXEL_W-1:0]     in_texel,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CORNER_W-1:0]    out_map_index,
  output logic [COORD_W-1:0]     out_pixel_column,
  output logic [COORD_W-1:0]     out_pixel_row,
  output logic                   out_block_last
);

  // configuration registers
  logic [MIP_W-1:0] mip_level_r;
  logic             pixel_mode_r;

  // block state: edge lights, steps, row interpolation and counters
  blk_state_t  state_r;
  blk_state_t  state_nxt;
  blk_state_t  setup_state;
  blk_state_t  texel_state;
  pix_result_t texel_result;
  corners_t    corners;

  // output register
  logic        out_valid_r;
  pix_result_t out_r;

  logic        in_accept;
  logic        out_free;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // the output register can take a new result when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && out_free;

  assign corners = '{top_left:     in_corner_top_left,
                     top_right:    in_corner_top_right,
                     bottom_left:  in_corner_bottom_left,
                     bottom_right: in_corner_bottom_right};

  // start transaction: load corner lights and per-row edge steps
  lti_edge_setup u_edge_setup (
    .corners   (corners),
    .mip_level (mip_level_r),
    .state_nxt (setup_state)
  );

  // texel transaction: row interpolation, colormap index, counter advance
  lti_texel_path u_texel_path (
    .state      (state_r),
    .mip_level  (mip_level_r),
    .pixel_mode (pixel_mode_r),
    .texel      (in_texel),
    .state_nxt  (texel_state),
    .result     (texel_result)
  );

  always_comb begin
    state_nxt = state_r;
    if (in_accept) begin
      state_nxt = (in_req_type == REQ_TEXEL) ? texel_state : setup_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mip_level_r  <= '0;
      pixel_mode_r <= MODE_8BIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIP_LEVEL:  mip_level_r  <= cfg_wdata[MIP_W-1:0];
        CFG_PIXEL_MODE: pixel_mode_r <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result stage: loads on an accepted texel, empties once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_req_type == REQ_TEXEL) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_req_type == REQ_TEXEL) begin
      out_r <= texel_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_map_index    = out_r.map_index;
  assign out_pixel_column = out_r.pixel_column;
  assign out_pixel_row    = out_r.pixel_row;
  assign out_block_last   = out_r.block_last;

endmodule

[hdl/lti_checker.sv]
module lti_checker
  import lti_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_req_type,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CORNER_W-1:0] out_map_index,
  input logic [COORD_W-1:0]  out_pixel_row,
  input logic                out_block_last
);

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // an accepted texel transaction gives a result next cycle
  a_texel_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == REQ_TEXEL) |=> out_valid)
    else $error("texel transaction gave no result");

  // a start transaction gives no result
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == REQ_START) |=> !out_valid)
    else $error("start transaction gave a result");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_map_index)))
    else $error("stalled result changed");

  // the block edge is at least two, so the last pixel is never in row zero
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_last) |-> (out_pixel_row != '0))
    else $error("block end flagged in the first row");

endmodule

bind lit_texel_block_interpolator_core lti_checker u_lti_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_map_index  (out_map_index),
  .out_pixel_row  (out_pixel_row),
  .out_block_last (out_block_last)
);

[dv/tb_lit_texel_block_interpolator_core.sv]
module tb_lit_texel_block_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lti_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int SETTLE_CYCLES  = 3;     // result is registered and shows in the cycle after the transaction
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PCT       = 22;

  // one transaction on the input channel
  typedef struct packed {
    logic               req;
    corners_t           c;
    logic [TEXEL_W-1:0] texel;
  } txn_t;

  // one row of the directed table: setting, transaction, optional typed-in pixel
  typedef struct packed {
    logic [MIP_W-1:0] mip;
    logic             mode;
    txn_t             t;
    bit               typed;
    pix_result_t      want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIP_LEVEL;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_req_type = REQ_START;
  logic [CORNER_W-1:0]    in_corner_top_left = '0;
  logic [CORNER_W-1:0]    in_corner_top_right = '0;
  logic [CORNER_W-1:0]    in_corner_bottom_left = '0;
  logic [CORNER_W-1:0]    in_corner_bottom_right = '0;
  logic [TEXEL_W-1:0]     in_texel = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CORNER_W-1:0]    out_map_index;
  logic [COORD_W-1:0]     out_pixel_column;
  logic [COORD_W-1:0]     out_pixel_row;
  logic                   out_block_last;

  lit_texel_block_interpolator_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_corner_top_left     (in_corner_top_left),
    .in_corner_top_right    (in_corner_top_right),
    .in_corner_bottom_left  (in_corner_bottom_left),
    .in_corner_bottom_right (in_corner_bottom_right),
    .in_texel               (in_texel),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_map_index          (out_map_index),
    .out_pixel_column       (out_pixel_column),
    .out_pixel_row          (out_pixel_row),
    .out_block_last         (out_block_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shadow copy of the block: configuration, edge lights, row run and counters
  logic [MIP_W-1:0]   cfg_mip  = '0;
  logic               cfg_mode = MODE_8BIT;
  light_t             left_light  = '0;
  light_t             right_light = '0;
  light_t             left_step   = '0;
  light_t             right_step  = '0;
  light_t             run_light   = '0;
  light_t             run_step    = '0;
  logic [COORD_W-1:0] row_cnt = '0;
  logic [COORD_W-1:0] col_cnt = '0;

  pix_result_t pending_pixels[$];   // lit pixels still owed by the block
  int          error_count = 0;
  int          items_sent  = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;         // no idling on either side while set

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // lights one transaction; returns 1 when it yields a pixel
  function automatic bit shade_item(input txn_t t, output pix_result_t px);
    int unsigned             sh;
    int unsigned             side;
    int unsigned             col_idx;
    logic signed [LIGHT_W:0] span;
    logic signed [LIGHT_W:0] scaled;
    light_t                  lit;
    sh   = 4 - cfg_mip;
    side = 16 >> cfg_mip;
    px   = '0;
    if (t.req == REQ_START) begin
      // corners are unsigned 8.8, steps are floor-shifted differences
      left_light  = {4'b0, t.c.top_left};
      right_light = {4'b0, t.c.top_right};
      span        = $signed({5'b0, t.c.bottom_left}) - $signed({5'b0, t.c.top_left});
      scaled      = span >>> sh;
      left_step   = scaled[LIGHT_W-1:0];
      span        = $signed({5'b0, t.c.bottom_right}) - $signed({5'b0, t.c.top_right});
      scaled      = span >>> sh;
      right_step  = scaled[LIGHT_W-1:0];
      run_light   = '0;
      run_step    = '0;
      row_cnt     = '0;
      col_cnt     = '0;
      return 1'b0;
    end
    // a row run starts from one edge and walks toward the other
    if (col_cnt == 0) begin
      if (cfg_mode == MODE_WIDE) begin
        run_light = left_light;
        span = {right_light[LIGHT_W-1], right_light} - {left_light[LIGHT_W-1], left_light};
      end else begin
        run_light = right_light;
        span = {left_light[LIGHT_W-1], left_light} - {right_light[LIGHT_W-1], right_light};
      end
      scaled   = span >>> sh;
      run_step = scaled[LIGHT_W-1:0];
    end
    lit = run_light;
    // smallest wide block: second column is the edge midpoint
    if (cfg_mode == MODE_WIDE && cfg_mip == MIP_SMALLEST && col_cnt == 1) begin
      span   = {left_light[LIGHT_W-1], left_light} + {right_light[LIGHT_W-1], right_light};
      scaled = span >>> 1;
      lit    = scaled[LIGHT_W-1:0];
    end
    col_idx = side - 1 - col_cnt;
    px.map_index    = (lit[CORNER_W-1:0] & LIGHT_HI_MASK) + {8'h00, t.texel};
    px.pixel_column = (cfg_mode == MODE_WIDE) ? col_cnt : col_idx[COORD_W-1:0];
    px.pixel_row    = row_cnt;
    run_light = run_light + run_step;
    if (col_cnt + 1 >= side) begin
      col_cnt     = '0;
      left_light  = left_light + left_step;
      right_light = right_light + right_step;
      if (row_cnt + 1 >= side) begin
        px.block_last = 1'b1;
        row_cnt = '0;
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [CORNER_W-1:0] rand_corner();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CORNER_W'($urandom);
    endcase
  endfunction

  function automatic txn_t rand_txn(input logic req);
    txn_t t;
    t.req            = req;
    t.c.top_left     = rand_corner();
    t.c.top_right    = rand_corner();
    t.c.bottom_left  = rand_corner();
    t.c.bottom_right = rand_corner();
    t.texel          = TEXEL_W'($urandom);
    return t;
  endfunction

  function automatic dir_row_t drow(input logic [MIP_W-1:0] mip, input logic mode,
                                    input logic req, input logic [CORNER_W-1:0] tl,
                                    input logic [CORNER_W-1:0] tr,
                                    input logic [CORNER_W-1:0] bl,
                                    input logic [CORNER_W-1:0] br,
                                    input logic [TEXEL_W-1:0] tx, input bit typed,
                                    input logic [CORNER_W-1:0] map,
                                    input logic [COORD_W-1:0] col,
                                    input logic [COORD_W-1:0] row, input logic last);
    dir_row_t r;
    r.mip   = mip;
    r.mode  = mode;
    r.t     = '{req, '{tl, tr, bl, br}, tx};
    r.typed = typed;
    r.want  = '{map, col, row, last};
    return r;
  endfunction

  // one input transaction, with an optional random gap in front of it
  task automatic send_item(input txn_t t, input bit typed, input pix_result_t want);
    pix_result_t px;
    bit          made;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_req_type            <= t.req;
    in_corner_top_left     <= t.c.top_left;
    in_corner_top_right    <= t.c.top_right;
    in_corner_bottom_left  <= t.c.bottom_left;
    in_corner_bottom_right <= t.c.bottom_right;
    in_texel               <= t.texel;
    do @(posedge clk); while (in_stall);
    made = shade_item(t, px);
    if (made) pending_pixels.push_back(typed ? want : px);
    items_sent++;
  endtask

  // sender holds off until every owed pixel is out, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes both registers back to back, valid held high across the pair
  task automatic write_setting(input logic [MIP_W-1:0] mip, input logic mode);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIP_LEVEL;
    cfg_wdata <= mip;
    do @(posedge clk); while (!cfg_ready);
    cfg_mip = mip;
    cfg_index <= CFG_PIXEL_MODE;
    cfg_wdata <= {1'($urandom), mode};   // upper bit is don't-care for this register
    do @(posedge clk); while (!cfg_ready);
    cfg_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  // result side: compare each pixel with the oldest owed one, stall at random
  always @(posedge clk) begin
    pix_result_t got;
    pix_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_map_index, out_pixel_column, out_pixel_row, out_block_last};
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel: map %h col %0d row %0d last %0d",
                             got.map_index, got.pixel_column, got.pixel_row,
                             got.block_last));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want)
          flag_error($sformatf({"pixel mismatch: expected map %h col %0d row %0d last %0d,",
                                " got map %h col %0d row %0d last %0d"},
                               want.map_index, want.pixel_column, want.pixel_row,
                               want.block_last, got.map_index, got.pixel_column,
                               got.pixel_row, got.block_last));
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog: counts cycles in which no transaction of any kind completes
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t          dir_rows[$];
    logic [MIP_W-1:0]  mip;
    logic              mode;
    int                side;
    int                kind;
    int                dir_count;
    bit                first_random;

    // directed table: setting, request, corners, texel, typed pixel if any
    // texels before any start work on the cleared state
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_TEXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            8'hFF, 1, 16'h00FF, 15, 0, 0));
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_TEXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            8'h00, 1, 16'h0000, 14, 0, 0));
    // all corners at full light, flat block
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0,
                            8'hA5, 1, 16'hFFA5, 15, 0, 0));
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0,
                            8'h5A, 1, 16'hFF5A, 14, 0, 0));
    // steepest gradients, one rising and one falling edge
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_START, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                            8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0,
                            8'h00, 1, 16'hFF00, 15, 0, 0));
    dir_rows.push_back(drow(0, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0, 0));
    // smallest wide block: midpoint column, last pixel, then running past the bottom
    dir_rows.push_back(drow(3, MODE_WIDE, REQ_START, 16'h1000, 16'h3000, 16'h5000, 16'h7000,
                            8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(3, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0,
                            8'h11, 1, 16'h1011, 0, 0, 0));
    dir_rows.push_back(drow(3, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0,
                            8'h22, 1, 16'h2022, 1, 0, 0));
    dir_rows.push_back(drow(3, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0,
                            8'h33, 1, 16'h3033, 0, 1, 0));
    dir_rows.push_back(drow(3, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0,
                            8'h44, 1, 16'h4044, 1, 1, 1));
    dir_rows.push_back(drow(3, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0,
                            8'h55, 1, 16'h5055, 0, 0, 0));
    // smallest 8-bit block, right to left
    dir_rows.push_back(drow(3, MODE_8BIT, REQ_START, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                            8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(3, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0,
                            8'h01, 1, 16'h0001, 1, 0, 0));
    dir_rows.push_back(drow(3, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0,
                            8'h02, 1, 16'h7F02, 0, 0, 0));
    dir_rows.push_back(drow(3, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0, 8'hC3, 0, 0, 0, 0, 0));
    // setting changed in the middle of a row
    dir_rows.push_back(drow(1, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0, 8'h3C, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(1, MODE_WIDE, REQ_START, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
                            8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(1, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0, 8'h80, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(1, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0, 8'h7F, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(1, MODE_WIDE, REQ_TEXEL, 0, 0, 0, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(2, MODE_8BIT, REQ_START, 16'h0123, 16'hFEDC, 16'hABCD, 16'h5432,
                            8'h00, 0, 0, 0, 0, 0));
    dir_rows.push_back(drow(2, MODE_8BIT, REQ_TEXEL, 0, 0, 0, 0, 8'h96, 0, 0, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reconfiguring whenever the table's setting moves
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mip != cfg_mip || dir_rows[i].mode != cfg_mode) begin
        drain();
        write_setting(dir_rows[i].mip, dir_rows[i].mode);
      end
      send_item(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
    end
    dir_count = items_sent;

    // random part: one setting per phase, mostly whole blocks
    first_random = 1'b1;
    while (items_sent - dir_count < RANDOM_ITEMS) begin
      drain();
      mip  = (first_random || $urandom_range(9) == 0) ? 2'd0 : MIP_W'($urandom_range(3, 1));
      mode = 1'($urandom_range(1));
      write_setting(mip, mode);
      side = 16 >> mip;
      // one long stretch with no idling, then now and then
      calm = first_random || ($urandom_range(7) == 0);
      kind = first_random ? 0 : $urandom_range(9);
      first_random = 1'b0;
      if (kind <= 6) begin
        repeat ($urandom_range(2, 1)) begin
          send_item(rand_txn(REQ_START), 0, '0);
          repeat (side * side) send_item(rand_txn(REQ_TEXEL), 0, '0);
        end
      end else if (kind == 7) begin
        // broken block: maybe no start, run ends anywhere
        if ($urandom_range(1)) send_item(rand_txn(REQ_START), 0, '0);
        repeat ($urandom_range(side * side + side, 1)) send_item(rand_txn(REQ_TEXEL), 0, '0);
      end else begin
        // noise: starts and texels mixed
        repeat ($urandom_range(30, 8))
          send_item(rand_txn(($urandom_range(3) == 0) ? REQ_START : REQ_TEXEL), 0, '0);
      end
    end

    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0)
      flag_error($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
